// ----- src/md5_pkg.sv -----
// Package: MD5 constants, types and round helper functions.
`timescale 1ns / 1ps
package md5_pkg;

    localparam logic [31:0] InitA = 32'h67452301;
    localparam logic [31:0] InitB = 32'hefcdab89;
    localparam logic [31:0] InitC = 32'h98badcfe;
    localparam logic [31:0] InitD = 32'h10325476;
    localparam logic [7:0]  PadMark = 8'h80;
    localparam logic [5:0]  LenOffset = 6'd56;

    // Commands from controller to datapath.
    typedef struct packed {
        logic       restart;    // reload IV, clear length and fill
        logic       put;        // write put_byte into the buffer at fill
        logic [7:0] put_byte;
        logic       count;      // add 8 to bit length
        logic       comp_start; // load round regs from chain
        logic       comp_step;  // run one round
        logic       comp_fold;  // add round regs into chain
    } t_cmd;

    typedef struct packed {
        logic [5:0]  fill;
        logic [5:0]  round;
        logic [63:0] len;
    } t_status;

    function automatic logic [31:0] sine_k(input logic [5:0] r);
        logic [31:0] k [64];
        k = '{32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
              32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
              32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
              32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
              32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
              32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
              32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
              32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
              32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
              32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
              32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
              32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
              32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
              32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
              32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
              32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
        return k[r];
    endfunction

    function automatic logic [4:0] rot_amt(input logic [5:0] r);
        logic [4:0] s;
        case ({r[5:4], r[1:0]})
            4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
            4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
            4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'ha: s = 5'd16;  4'hb: s = 5'd23;
            4'hc: s = 5'd6;   4'hd: s = 5'd10;  4'he: s = 5'd15;  4'hf: s = 5'd21;
            default: s = 5'd7;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] msg_idx(input logic [5:0] r);
        logic [3:0] g;
        case (r[5:4])
            2'd0: g = r[3:0];
            2'd1: g = 4'(r[3:0] * 4'd5 + 4'd1);
            2'd2: g = 4'(r[3:0] * 4'd3 + 4'd5);
            default: g = 4'(r[3:0] * 4'd7);
        endcase
        return g;
    endfunction

endpackage

// ----- src/md5_hash_engine_core.sv -----
// Top level: MD5 engine, byte stream in, four digest words out.
//   channel | dir | tdata                       | tuser
//   s_axis  | in  | [7:0] data_byte             | [0] has_byte, [1] end_of_message
//   m_axis  | out | [31:0] digest_word          | [1:0] word_index, [2] last_word
// Each beat with a byte is taken only while idle; every 64th byte adds a
// compression (load, 64 rounds, fold) on the single shared round unit.
// End of message pads byte by byte, then compresses one or two blocks,
// then holds four result beats; input is stalled during all of that.
// Synchronous active-low reset reloads the initial chaining values.
`timescale 1ns / 1ps
module md5_hash_engine_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_axis_tuser,   // [0] has_byte, [1] end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser    // [1:0] word_index, [2] last_word
);
    import md5_pkg::*;

    t_cmd         w_cmd;
    t_status      w_status;
    logic [127:0] w_chain;
    logic [1:0]   w_idx;

    md5_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_byte   (s_axis_tdata),
        .i_has    (s_axis_tuser[0]),
        .i_eom    (s_axis_tuser[1]),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_idx    (w_idx)
    );

    md5_datapath u_dp (
        .i_clk    (i_clk),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .o_chain  (w_chain)
    );

    // Pick the chaining word for the current result beat.
    assign m_axis_tdata = w_chain[{w_idx, 5'd0} +: 32];
    assign m_axis_tuser = {w_idx == 2'd3, w_idx};
endmodule

// ----- src/md5_datapath.sv -----
// Datapath: block buffer, bit length, chaining words and the round unit.
`timescale 1ns / 1ps
module md5_datapath (
    input  logic              i_clk,
    input  md5_pkg::t_cmd     i_cmd,
    output md5_pkg::t_status  o_status,
    output logic [127:0]      o_chain
);
    import md5_pkg::*;

    logic [31:0] r_blk [16];
    logic [31:0] r_chain [4];
    logic [31:0] r_rr [4];
    logic [63:0] r_len;
    logic [5:0]  r_fill;
    logic [5:0]  r_round;
    logic [31:0] w_mix, w_t, w_rot;
    logic [31:0] b, c, d;

    assign b = r_rr[1];
    assign c = r_rr[2];
    assign d = r_rr[3];

    always_comb begin
        case (r_round[5:4])
            2'd0: w_mix = (b & c) | (~b & d);
            2'd1: w_mix = (b & d) | (c & ~d);
            2'd2: w_mix = b ^ c ^ d;
            default: w_mix = c ^ (b | ~d);
        endcase
        w_t = r_rr[0] + w_mix + sine_k(r_round) + r_blk[msg_idx(r_round)];
        w_rot = (w_t << rot_amt(r_round)) | (w_t >> (6'd32 - {1'b0, rot_amt(r_round)}));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.put) begin
            case (r_fill[1:0])
                2'd0: r_blk[r_fill[5:2]][7:0]   <= i_cmd.put_byte;
                2'd1: r_blk[r_fill[5:2]][15:8]  <= i_cmd.put_byte;
                2'd2: r_blk[r_fill[5:2]][23:16] <= i_cmd.put_byte;
                default: r_blk[r_fill[5:2]][31:24] <= i_cmd.put_byte;
            endcase
        end
        if (i_cmd.comp_start) begin
            for (int i = 0; i < 4; i++) r_rr[i] <= r_chain[i];
        end else if (i_cmd.comp_step) begin
            r_rr[0] <= d;
            r_rr[3] <= c;
            r_rr[2] <= b;
            r_rr[1] <= b + w_rot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.restart) begin
            r_chain[0] <= InitA;
            r_chain[1] <= InitB;
            r_chain[2] <= InitC;
            r_chain[3] <= InitD;
            r_len <= '0;
            r_fill <= '0;
            r_round <= '0;
        end else begin
            if (i_cmd.count) r_len <= r_len + 64'd8;
            if (i_cmd.put) r_fill <= r_fill + 6'd1;
            if (i_cmd.comp_start) r_round <= '0;
            else if (i_cmd.comp_step) r_round <= r_round + 6'd1;
            if (i_cmd.comp_fold) begin
                for (int i = 0; i < 4; i++) r_chain[i] <= r_chain[i] + r_rr[i];
            end
        end
    end

    assign o_status.fill = r_fill;
    assign o_status.round = r_round;
    assign o_status.len = r_len;
    assign o_chain = {r_chain[3], r_chain[2], r_chain[1], r_chain[0]};
endmodule

// ----- src/md5_ctrl.sv -----
// Controller: byte intake, padding sequencer, compression and digest output.
`timescale 1ns / 1ps
module md5_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_byte,
    input  logic              i_has,
    input  logic              i_eom,
    input  md5_pkg::t_status  i_status,
    output md5_pkg::t_cmd     o_cmd,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_idx
);
    import md5_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_PAD  = 6'b000010,
        S_LOAD = 6'b000100,
        S_RUN  = 6'b001000,
        S_FOLD = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state      r_state, n_state;
    logic        r_eom, n_eom;      // padding pending after the block
    logic        r_pad, n_pad;      // padding in progress
    logic        r_mark, n_mark;    // 0x80 still to go
    logic [63:0] r_tlen, n_tlen;
    logic [1:0]  r_idx, n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_eom <= 1'b0;
            r_pad <= 1'b0;
            r_mark <= 1'b0;
            r_idx <= '0;
        end else begin
            r_state <= n_state;
            r_eom <= n_eom;
            r_pad <= n_pad;
            r_mark <= n_mark;
            r_idx <= n_idx;
        end
        r_tlen <= n_tlen;
    end

    assign o_ready = (r_state == S_IDLE) && i_rst_n;
    assign o_valid = (r_state == S_OUT);
    assign o_idx = r_idx;

    always_comb begin
        n_state = r_state;
        n_eom = r_eom;
        n_pad = r_pad;
        n_mark = r_mark;
        n_tlen = r_tlen;
        n_idx = r_idx;
        o_cmd = '0;
        o_cmd.restart = !i_rst_n;
        case (r_state)
            S_IDLE: begin
                if (i_valid && i_rst_n) begin
                    if (i_has) begin
                        o_cmd.put = 1'b1;
                        o_cmd.put_byte = i_byte;
                        o_cmd.count = 1'b1;
                    end
                    n_tlen = i_status.len + (i_has ? 64'd8 : 64'd0);
                    if (i_has && i_status.fill == 6'd63) begin
                        n_eom = i_eom;
                        n_pad = 1'b0;
                        n_mark = i_eom;
                        n_state = S_LOAD;
                    end else if (i_eom) begin
                        n_pad = 1'b1;
                        n_mark = 1'b1;
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                o_cmd.put = 1'b1;
                if (r_mark) begin
                    o_cmd.put_byte = PadMark;
                    n_mark = 1'b0;
                    // mark at or past the length slot: trailer moves to the next block
                    if (i_status.fill >= LenOffset) n_pad = 1'b0;
                end else if (r_pad && i_status.fill >= LenOffset) begin
                    case (i_status.fill[2:0])
                        3'd0: o_cmd.put_byte = r_tlen[7:0];
                        3'd1: o_cmd.put_byte = r_tlen[15:8];
                        3'd2: o_cmd.put_byte = r_tlen[23:16];
                        3'd3: o_cmd.put_byte = r_tlen[31:24];
                        3'd4: o_cmd.put_byte = r_tlen[39:32];
                        3'd5: o_cmd.put_byte = r_tlen[47:40];
                        3'd6: o_cmd.put_byte = r_tlen[55:48];
                        default: o_cmd.put_byte = r_tlen[63:56];
                    endcase
                end else begin
                    o_cmd.put_byte = 8'h00;
                end
                if (i_status.fill == 6'd63) begin
                    // another padding block follows unless the trailer landed here
                    n_eom = r_mark || !r_pad;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.comp_start = 1'b1;
                n_state = S_RUN;
            end
            S_RUN: begin
                o_cmd.comp_step = 1'b1;
                if (i_status.round == 6'd63) n_state = S_FOLD;
            end
            S_FOLD: begin
                o_cmd.comp_fold = 1'b1;
                if (r_eom) begin
                    n_eom = 1'b0;
                    n_pad = 1'b1;
                    n_state = S_PAD;
                end else if (r_pad) begin
                    n_idx = '0;
                    n_state = S_OUT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (i_ready) begin
                    n_idx = r_idx + 2'd1;
                    if (r_idx == 2'd3) begin
                        o_cmd.restart = 1'b1;
                        n_pad = 1'b0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
